/* rtl/base64_stream_encoder_unit_assert.svh */
// Assertion macros shared by the base64 stream encoder RTL.
// Depends on nothing; included by the top level only.
`ifndef BASE64_STREAM_ENCODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_ENCODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64E_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/b64e_pkg.sv */
// Types, constants and the alphabet function of the base64 stream encoder.
// Depends on nothing; used by the front end, queue, back end and top level.
package b64e_pkg;

  localparam logic [7:0] B64E_PAD_CHAR = 8'h3D;

  localparam logic [2:0] B64E_CNT_NONE = 3'd0;
  localparam logic [2:0] B64E_CNT_TWO  = 3'd2;
  localparam logic [2:0] B64E_CNT_FOUR = 3'd4;

  typedef struct packed {
    logic       pad;
    logic [5:0] idx;
  } b64e_sym_t;

  typedef struct packed {
    b64e_sym_t [3:0] sym;
    logic [1:0]      last_idx;
    logic            eom;
  } b64e_job_t;

  typedef struct packed {
    logic       accept;
    logic [2:0] res_cnt;
  } b64e_front_stat_t;

  typedef struct packed {
    logic empty;
    logic full;
  } b64e_q_stat_t;

  function automatic logic [7:0] b64e_char(input b64e_sym_t s);
    logic [7:0] ch;
    ch = B64E_PAD_CHAR;
    if (!s.pad) begin
      case (s.idx) inside
        [6'd0:6'd25]:  ch = 8'h41 + {2'b00, s.idx};
        [6'd26:6'd51]: ch = 8'h61 + {2'b00, s.idx} - 8'd26;
        [6'd52:6'd61]: ch = 8'h30 + {2'b00, s.idx} - 8'd52;
        6'd62:         ch = 8'h2B;
        default:       ch = 8'h2F;
      endcase
    end
    return ch;
  endfunction

endpackage

/* rtl/b64e_in_if.sv */
// Input channel of the base64 stream encoder: one raw byte per request.
// Depends on nothing.
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source(output valid, data_byte, final_byte, input ready);
  modport sink(input valid, data_byte, final_byte, output ready);
endinterface

/* rtl/b64e_out_if.sv */
// Result channel of the base64 stream encoder: one character per request.
// Depends on nothing.
interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       end_of_message;

  modport source(output valid, out_char, end_of_message, input ready);
  modport sink(input valid, out_char, end_of_message, output ready);
endinterface

/* rtl/b64e_front.sv */
// Front end: accepts bytes, holds the residue bits and builds a character job.
// Depends on b64e_pkg and b64e_in_if.
module b64e_front (
  input  logic                      clk,
  input  logic                      rst_n,
  b64e_in_if.sink                   in_chan,
  input  b64e_pkg::b64e_q_stat_t    q_stat,
  output logic                      push,
  output b64e_pkg::b64e_job_t       job,
  output b64e_pkg::b64e_front_stat_t stat
);

  logic [3:0]  res_bits_r, res_bits_nxt;
  logic [2:0]  res_cnt_r, res_cnt_nxt;
  logic [11:0] win;
  logic        accept;

  assign in_chan.ready = !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign push          = accept;
  assign stat.accept   = accept;
  assign stat.res_cnt  = res_cnt_r;

  always_comb begin
    case (res_cnt_r)
      b64e_pkg::B64E_CNT_NONE: win = {in_chan.data_byte, 4'b0000};
      b64e_pkg::B64E_CNT_TWO:  win = {res_bits_r[1:0], in_chan.data_byte, 2'b00};
      default:                 win = {res_bits_r, in_chan.data_byte};
    endcase

    job.sym[0] = '{pad: 1'b0, idx: win[11:6]};
    job.sym[1] = '{pad: 1'b0, idx: win[5:0]};
    job.sym[2] = '{pad: 1'b1, idx: 6'd0};
    job.sym[3] = '{pad: 1'b1, idx: 6'd0};
    job.eom    = in_chan.final_byte;

    case (res_cnt_r)
      b64e_pkg::B64E_CNT_NONE: begin
        job.last_idx = in_chan.final_byte ? 2'd3 : 2'd0;
        res_bits_nxt = {2'b00, in_chan.data_byte[1:0]};
        res_cnt_nxt  = b64e_pkg::B64E_CNT_TWO;
      end
      b64e_pkg::B64E_CNT_TWO: begin
        job.last_idx = in_chan.final_byte ? 2'd2 : 2'd0;
        res_bits_nxt = in_chan.data_byte[3:0];
        res_cnt_nxt  = b64e_pkg::B64E_CNT_FOUR;
      end
      default: begin
        job.last_idx = 2'd1;
        res_bits_nxt = 4'd0;
        res_cnt_nxt  = b64e_pkg::B64E_CNT_NONE;
      end
    endcase

    if (in_chan.final_byte) begin
      res_bits_nxt = 4'd0;
      res_cnt_nxt  = b64e_pkg::B64E_CNT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_bits_r <= 4'd0;
      res_cnt_r  <= b64e_pkg::B64E_CNT_NONE;
    end else if (accept) begin
      res_bits_r <= res_bits_nxt;
      res_cnt_r  <= res_cnt_nxt;
    end
  end

endmodule

/* rtl/b64e_fifo.sv */
// Short job queue between the front end and the character emitter.
// Depends on b64e_pkg.
module b64e_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  b64e_pkg::b64e_job_t    push_job,
  input  logic                   pop,
  output b64e_pkg::b64e_job_t    head,
  output b64e_pkg::b64e_q_stat_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  b64e_pkg::b64e_job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head       = mem[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_FULL);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

/* rtl/b64e_back.sv */
// Back end: drives a job's characters, one per cycle unless stalled.
// Depends on b64e_pkg and b64e_out_if.
module b64e_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  b64e_pkg::b64e_job_t    head,
  input  b64e_pkg::b64e_q_stat_t q_stat,
  output logic                   pop,
  b64e_out_if.source             out_chan
);

  b64e_pkg::b64e_job_t job_r;
  logic                job_valid_r;
  logic [1:0]          idx_r;
  logic                out_valid_r;
  logic [7:0]          out_char_r;
  logic                out_eom_r;
  logic                out_load;
  logic                job_done;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.out_char       = out_char_r;
  assign out_chan.end_of_message = out_eom_r;

  assign out_load = job_valid_r && (!out_valid_r || out_chan.ready);
  assign job_done = out_load && (idx_r == job_r.last_idx);
  assign pop      = !q_stat.empty && (!job_valid_r || job_done);

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head;
    end
    if (out_load) begin
      out_char_r <= b64e_pkg::b64e_char(job_r.sym[idx_r]);
      out_eom_r  <= job_r.eom && job_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        job_valid_r <= 1'b1;
        idx_r       <= 2'd0;
      end else if (job_done) begin
        job_valid_r <= 1'b0;
      end else if (out_load) begin
        idx_r <= idx_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* rtl/base64_stream_encoder_unit.sv */
// Top level of the base64 stream encoder: front end, job queue, emitter.
// Depends on b64e_pkg, b64e_in_if, b64e_out_if, b64e_front, b64e_fifo, b64e_back.
//
//   Channel   Direction  Request carries
//   in_chan   sink       data_byte, final_byte
//   out_chan  source     out_char, end_of_message
//
// A byte is taken whenever the queue has room, and its characters leave one per
// cycle from the output register while the receiver is ready: one or two for an
// ordinary byte, up to four for a final byte, so the output port sets the rate.
// A byte passes through the queue, the job register and the output register.
// Reset is synchronous and clears the residue, the queue and the output valid.
// A stalled output holds its character; the queue takes bytes until it is full.
module base64_stream_encoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  b64e_in_if.sink      in_chan,
  b64e_out_if.source   out_chan
);

  `include "base64_stream_encoder_unit_assert.svh"

  logic                       push;
  logic                       pop;
  b64e_pkg::b64e_job_t        push_job;
  b64e_pkg::b64e_job_t        head;
  b64e_pkg::b64e_q_stat_t     q_stat;
  b64e_pkg::b64e_front_stat_t f_stat;

  b64e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_stat  (q_stat),
    .push    (push),
    .job     (push_job),
    .stat    (f_stat)
  );

  b64e_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  b64e_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

  `B64E_ASSERT_SAME(a_res_cnt_legal, clk, rst_n, 1'b1,
    f_stat.res_cnt == b64e_pkg::B64E_CNT_NONE || f_stat.res_cnt == b64e_pkg::B64E_CNT_TWO ||
    f_stat.res_cnt == b64e_pkg::B64E_CNT_FOUR, "residue count left the legal set")
  `B64E_ASSERT_NEXT(a_final_clears, clk, rst_n, f_stat.accept && in_chan.final_byte,
    f_stat.res_cnt == b64e_pkg::B64E_CNT_NONE, "final byte did not clear the residue")
  `B64E_ASSERT_NEXT(a_push_lands, clk, rst_n, f_stat.accept,
    !q_stat.empty, "accepted byte did not reach the job queue")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for base64_stream_encoder_unit: directed and random byte
// messages, with the expected characters worked out by a predictor in this file.
// Depends on b64e_pkg, b64e_in_if, b64e_out_if and the encoder RTL.
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_SLACK = 20;
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0] ch;
    logic       eom;
  } b64_char_t;

  logic clk;
  logic rst_n;

  b64e_in_if  in_chan();
  b64e_out_if out_chan();

  base64_stream_encoder_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  b64_char_t   pending_chars[$];
  b64_char_t   front_char;
  logic [3:0]  carry_bits;
  int unsigned carry_len;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned msgs_sent;
  int unsigned chars_checked;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] symbol_of(input logic [5:0] idx);
    return ALPHABET[8*(63 - idx) +: 8];
  endfunction

  function automatic void push_char(input logic [7:0] ch);
    b64_char_t c;
    c.ch = ch;
    c.eom = 1'b0;
    pending_chars.push_back(c);
  endfunction

  // Appends the characters one accepted byte must produce and advances the carry.
  function automatic void encode_byte(input logic [7:0] data, input logic fin);
    logic [11:0] joined;
    logic [11:0] tail;
    int unsigned avail;
    b64_char_t   last_char;
    joined = {carry_bits, data};
    avail = carry_len + 8;
    while (avail >= 6) begin
      avail -= 6;
      tail = joined >> avail;
      push_char(symbol_of(tail[5:0]));
    end
    if (!fin) begin
      carry_len = avail;
      carry_bits = joined[3:0] & ((4'd1 << avail) - 4'd1);
      return;
    end
    if (avail != 0) begin
      tail = (joined & ((12'd1 << avail) - 12'd1)) << (6 - avail);
      push_char(symbol_of(tail[5:0]));
      push_char(b64e_pkg::B64E_PAD_CHAR);
      if (avail == 2) push_char(b64e_pkg::B64E_PAD_CHAR);
    end
    last_char = pending_chars.pop_back();
    last_char.eom = 1'b1;
    pending_chars.push_back(last_char);
    carry_bits = '0;
    carry_len = 0;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 100) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic send_byte(input logic [7:0] data, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.data_byte  <= data;
    in_chan.final_byte <= fin;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    encode_byte(data, fin);
    bytes_sent++;
    if (fin) msgs_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h4D, 1'b1);
    wait_drained();
  endtask

  // The sender holds back mid-message until the output has gone quiet, so the
  // carried bits must survive an idle pipeline.
  task automatic test_pause_mid_message(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    send_byte(8'($urandom_range(255)), 1'b0);
    wait_drained();
    send_byte(8'($urandom_range(255)), 1'b0);
    wait_drained();
    send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(8'($urandom_range(255)), 1'b1);
    wait_drained();
  endtask

  task automatic test_random_messages(input int unsigned n_bytes, input int unsigned tx_pct,
                                      input int unsigned rx_pct);
    int unsigned start;
    int unsigned pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 80) send_message($urandom_range(6, 1));
      else if (pick < 95) send_message($urandom_range(20, 7));
      else send_message($urandom_range(40, 21));
    end
    wait_drained();
  endtask

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h eom %b",
                                  out_chan.out_char, out_chan.end_of_message));
      end else begin
        front_char = pending_chars.pop_front();
        chars_checked++;
        if (out_chan.out_char !== front_char.ch)
          report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                    out_chan.out_char, front_char.ch));
        if (out_chan.end_of_message !== front_char.eom)
          report_mismatch($sformatf("end_of_message %b, expected %b on 0x%02h",
                                    out_chan.end_of_message, front_char.eom, front_char.ch));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycle_count,
               pending_chars.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data_byte = '0;
    in_chan.final_byte = 1'b0;
    out_chan.ready = 1'b0;
    carry_bits = '0;
    carry_len = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    error_count = 0;
    cycle_count = 0;
    bytes_sent = 0;
    msgs_sent = 0;
    chars_checked = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_pause_mid_message(31, 56);
    test_random_messages(145, 31, 56);
    test_random_messages(145, 56, 31);
    test_pause_mid_message(56, 31);
    test_random_messages(145, 0, 0);

    $display("Encoded %0d bytes in %0d messages and checked %0d characters,",
             bytes_sent, msgs_sent, chars_checked);
    $display("under sender and receiver stalls, mid-message pauses and full rate.");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* base64_stream_encoder_unit.f */
+incdir+rtl
rtl/b64e_pkg.sv
rtl/b64e_in_if.sv
rtl/b64e_out_if.sv
rtl/b64e_front.sv
rtl/b64e_fifo.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder_unit.sv
sim/tb_top.sv
